@@ sv/tcp_ip_checksum_engine_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the checksum engine
// Clocked on clk and disabled while rst is high; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef TCP_IP_CHECKSUM_ENGINE_ASSERT_SVH
`define TCP_IP_CHECKSUM_ENGINE_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define TCE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("checksum engine assertion failed");

// next-cycle implication
`define TCE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("checksum engine assertion failed");

`else

`define TCE_ASSERT_IMP(name, ante, cons)
`define TCE_ASSERT_NXT(name, ante, cons)

`endif

`endif

@@ sv/tcpcs_pkg.sv @@
// ---------------------------------------------------------------------------
// tcpcs_pkg
// Constants, register indexes and ones' complement helpers for the engine.
// ---------------------------------------------------------------------------
`default_nettype none

package tcpcs_pkg;

  localparam logic [15:0] MAX_BLOCK_BYTES = 16'd65535;
  localparam logic [7:0]  PROTO_TCP       = 8'h06;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_TCP4  = 2'd1;
  localparam logic [1:0] MODE_TCP6  = 2'd2;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_SRC_HIGH  = 3'd1;
  localparam logic [2:0] REG_SRC_LOW   = 3'd2;
  localparam logic [2:0] REG_DST_HIGH  = 3'd3;
  localparam logic [2:0] REG_DST_LOW   = 3'd4;
  localparam logic [2:0] REG_PROTOCOL  = 3'd5;

  // 16-bit add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // fold a 21-bit raw word sum down to 16 bits
  function automatic logic [15:0] fold21(input logic [20:0] x);
    logic [16:0] f;
    f = {1'b0, x[15:0]} + {12'd0, x[20:16]};
    return f[15:0] + {15'd0, f[16]};
  endfunction

endpackage

`default_nettype wire

@@ sv/tcp_ip_checksum_engine.sv @@
// ---------------------------------------------------------------------------
// tcp_ip_checksum_engine
// Streaming RFC 1071 checksum with optional TCP pseudo-header (IPv4/IPv6).
// ---------------------------------------------------------------------------
// Takes one byte per cycle on the slave stream; tlast ends a block. A result
// leaves the master stream after the last byte is taken, through
// a two-stage finish pipeline and an output register; the whole pipeline
// holds while a result waits, so input ready drops only then. The
// pseudo-header part of the sum is kept in registers (cfg_src_raw,
// cfg_dst_raw, then cfg_fold) that follow the configuration registers.
// Bytes past 65535 are dropped and flagged as length overflow.
`default_nettype none

module tcp_ip_checksum_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [15:0] checksum_value, [31:16] byte_total,
                                      // [32] length_overflow, [39:33] zero
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [63:0] wr_data
);

  // configuration
  logic [1:0]  checksum_mode;
  logic [63:0] source_addr_high;
  logic [63:0] source_addr_low;
  logic [63:0] dest_addr_high;
  logic [63:0] dest_addr_low;
  logic [7:0]  protocol_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_mode    <= tcpcs_pkg::MODE_TCP4;
      source_addr_high <= '0;
      source_addr_low  <= '0;
      dest_addr_high   <= '0;
      dest_addr_low    <= '0;
      protocol_number  <= tcpcs_pkg::PROTO_TCP;
    end else if (wr_en) begin
      case (wr_index)
        tcpcs_pkg::REG_MODE:     checksum_mode    <= wr_data[1:0];
        tcpcs_pkg::REG_SRC_HIGH: source_addr_high <= wr_data;
        tcpcs_pkg::REG_SRC_LOW:  source_addr_low  <= wr_data;
        tcpcs_pkg::REG_DST_HIGH: dest_addr_high   <= wr_data;
        tcpcs_pkg::REG_DST_LOW:  dest_addr_low    <= wr_data;
        tcpcs_pkg::REG_PROTOCOL: protocol_number  <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  // pseudo-header sum, split into source and destination halves
  logic        mode_tcp4;
  logic        mode_tcp6;
  logic        mode_len;
  logic [18:0] cfg_src_raw_next;
  logic [19:0] cfg_dst_raw_next;
  logic [18:0] cfg_src_raw;
  logic [19:0] cfg_dst_raw;
  logic [15:0] cfg_fold;

  assign mode_tcp4 = (checksum_mode == tcpcs_pkg::MODE_TCP4);
  assign mode_tcp6 = (checksum_mode == tcpcs_pkg::MODE_TCP6);
  assign mode_len  = mode_tcp4 | mode_tcp6;

  always_comb begin
    cfg_src_raw_next = '0;
    cfg_dst_raw_next = '0;
    if (mode_tcp6) begin
      for (int i = 0; i < 4; i++) begin
        cfg_src_raw_next = cfg_src_raw_next
                         + {3'd0, source_addr_high[16*i +: 16]}
                         + {3'd0, source_addr_low[16*i +: 16]};
        cfg_dst_raw_next = cfg_dst_raw_next
                         + {4'd0, dest_addr_high[16*i +: 16]}
                         + {4'd0, dest_addr_low[16*i +: 16]};
      end
    end else if (mode_tcp4) begin
      cfg_src_raw_next = {3'd0, source_addr_low[31:16]} + {3'd0, source_addr_low[15:0]};
      cfg_dst_raw_next = {4'd0, dest_addr_low[31:16]} + {4'd0, dest_addr_low[15:0]};
    end
    if (mode_len) begin
      cfg_dst_raw_next = cfg_dst_raw_next + {12'd0, protocol_number};
    end
  end

  always_ff @(posedge clk) begin
    cfg_src_raw <= cfg_src_raw_next;
    cfg_dst_raw <= cfg_dst_raw_next;
    cfg_fold    <= tcpcs_pkg::fold21({2'd0, cfg_src_raw} + {1'b0, cfg_dst_raw});
  end

  // handshake: whole pipeline holds while a result waits
  logic en;
  logic s_acc;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign s_acc    = s_tvalid && en;

  // byte accumulation
  logic [15:0] running_sum;
  logic [7:0]  pending_high_byte;
  logic        odd_position;
  logic [15:0] bytes_seen;
  logic        overflow_seen;
  logic        take_byte;
  logic [15:0] bytes_inc;
  logic [15:0] pair_word;
  logic [15:0] fin_word;

  assign take_byte = bytes_seen < tcpcs_pkg::MAX_BLOCK_BYTES;
  assign bytes_inc = bytes_seen + 16'd1;
  assign pair_word = {pending_high_byte, s_tdata};

  // word closing the block, trailing odd byte padded as the high byte
  always_comb begin
    if (take_byte) begin
      fin_word = odd_position ? pair_word : {s_tdata, 8'h00};
    end else begin
      fin_word = odd_position ? {pending_high_byte, 8'h00} : 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum       <= '0;
      pending_high_byte <= '0;
      odd_position      <= 1'b0;
      bytes_seen        <= '0;
      overflow_seen     <= 1'b0;
    end else if (s_acc) begin
      if (s_tlast) begin
        running_sum       <= '0;
        pending_high_byte <= '0;
        odd_position      <= 1'b0;
        bytes_seen        <= '0;
        overflow_seen     <= 1'b0;
      end else if (take_byte) begin
        bytes_seen <= bytes_inc;
        if (odd_position) begin
          running_sum       <= tcpcs_pkg::oc_add(running_sum, pair_word);
          pending_high_byte <= '0;
          odd_position      <= 1'b0;
        end else begin
          pending_high_byte <= s_tdata;
          odd_position      <= 1'b1;
        end
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // finish pipeline
  logic        s1_valid;
  logic [15:0] s1_sum;
  logic [15:0] s1_len;
  logic        s1_ovf;
  logic        s2_valid;
  logic [15:0] s2_sum;
  logic [15:0] s2_len;
  logic        s2_ovf;
  logic [15:0] out_checksum;
  logic [15:0] out_total;
  logic        out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_acc && s_tlast;
      s2_valid <= s1_valid;
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sum       <= tcpcs_pkg::oc_add(running_sum, fin_word);
      s1_len       <= take_byte ? bytes_inc : bytes_seen;
      s1_ovf       <= overflow_seen | !take_byte;
      s2_sum       <= tcpcs_pkg::oc_add(s1_sum, mode_len ? s1_len : 16'h0000);
      s2_len       <= s1_len;
      s2_ovf       <= s1_ovf;
      out_checksum <= ~tcpcs_pkg::oc_add(s2_sum, cfg_fold);
      out_total    <= s2_len;
      out_ovf      <= s2_ovf;
    end
  end

  assign m_tdata = {7'd0, out_ovf, out_total, out_checksum};

`include "tcp_ip_checksum_engine_assert.svh"

  `TCE_ASSERT_NXT(a_block_clear, s_acc && s_tlast, bytes_seen == 16'd0 && !odd_position)
  `TCE_ASSERT_IMP(a_ovf_at_max, overflow_seen, bytes_seen == tcpcs_pkg::MAX_BLOCK_BYTES)
  `TCE_ASSERT_IMP(a_out_ovf_len, m_tvalid && out_ovf, out_total == tcpcs_pkg::MAX_BLOCK_BYTES)
  `TCE_ASSERT_NXT(a_stall_hold, s2_valid && !en, s2_valid && m_tvalid)

endmodule

`default_nettype wire
